@@ hdl/cc_dir_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cache-Control directive parser package
// Shared types and directive name tables for the parser and its channels.
// ----------------------------------------------------------------------------
package cc_dir_pkg;

    localparam int unsigned ACC_W   = 63;
    localparam int unsigned NAMES_N = 4;

    // Indexes of the known directive names.
    localparam logic [1:0] NAME_NO_STORE        = 2'd0;
    localparam logic [1:0] NAME_NO_CACHE        = 2'd1;
    localparam logic [1:0] NAME_MUST_REVALIDATE = 2'd2;
    localparam logic [1:0] NAME_MAX_AGE         = 2'd3;

    // Names are left-justified in 16 byte slots, zero padded.
    localparam logic [127:0] KNOWN_NAME [NAMES_N] = '{
        {"no-store", 64'h0},
        {"no-cache", 64'h0},
        {"must-revalidate", 8'h0},
        {"max-age", 72'h0}
    };
    localparam logic [3:0] KNOWN_LEN [NAMES_N] = '{4'd8, 4'd8, 4'd15, 4'd7};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LOW   = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ITEM,
        PH_LEAD,
        PH_NAME,
        PH_VALUE
    } t_phase;

    typedef enum logic [2:0] {
        VP_PRE,
        VP_DIGITS,
        VP_QOPEN,
        VP_QDIGITS,
        VP_QCLOSED,
        VP_DONE,
        VP_BAD
    } t_vphase;

    typedef struct packed {
        t_phase             phase;
        logic [3:0]         name_pos;
        logic [3:0]         cand;
        logic               inner_space;
        logic               saw_equals;
        t_vphase            vphase;
        logic [ACC_W-1:0]   acc;
        logic [3:0]         flags;
        logic               error;
        logic               tab_pending;
    } t_state;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_value;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic             header_valid;
        logic             store_ban;
        logic             cache_ban;
        logic             reval_req;
        logic             age_present;
        logic [ACC_W-1:0] age_seconds;
    } t_out_req;

endpackage : cc_dir_pkg
`default_nettype wire

@@ hdl/cc_dir_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cache-Control parser channels
// Valid/ready channels for header bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface cc_dir_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, has_byte, byte_value, last, input ready);
    modport sink   (input valid, has_byte, byte_value, last, output ready);
endinterface : cc_dir_in_if

interface cc_dir_out_if;
    logic                         valid;
    logic                         ready;
    logic                         header_valid;
    logic                         store_ban;
    logic                         cache_ban;
    logic                         reval_req;
    logic                         age_present;
    logic [cc_dir_pkg::ACC_W-1:0] age_seconds;

    modport source (output valid, header_valid, store_ban, cache_ban, reval_req,
                    age_present, age_seconds, input ready);
    modport sink   (input valid, header_valid, store_ban, cache_ban, reval_req,
                    age_present, age_seconds, output ready);
endinterface : cc_dir_out_if
`default_nettype wire

@@ hdl/cache_control_directive_parser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cache-Control directive parser
// Parses a Cache-Control header value byte by byte and emits one verdict
// per header with the directive flags and the max-age value.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Request payload
//  i_hdr       in         has_byte, byte_value[7:0], last
//  o_verdict   out        header_valid, store_ban, cache_ban, reval_req,
//                         age_present, age_seconds[62:0]
//
// One request is taken every cycle unless the input register stalls. A
// request first lands in an input register; as it moves on, one pass of
// logic updates the parser state and, for a request marked last, loads the
// verdict register, from which the verdict is offered.
// The input register only stalls when it holds a last request and the
// verdict register still holds an untaken verdict; other requests never wait.
// Reset (synchronous, active low) returns the parser to the start of a header.
//
module cache_control_directive_parser_top (
    input  wire            i_clk,
    input  wire            i_rst_n,
    cc_dir_in_if.sink      i_hdr,
    cc_dir_out_if.source   o_verdict
);
    import cc_dir_pkg::*;

    // ------------------------------------------------------------------
    // Helper functions, one per step of the byte grammar.
    // ------------------------------------------------------------------

    // State after reset and after each verdict.
    function automatic t_state reset_state();
        t_state s;
        s.phase       = PH_HEADER;
        s.name_pos    = '0;
        s.cand        = 4'hf;
        s.inner_space = 1'b0;
        s.saw_equals  = 1'b0;
        s.vphase      = VP_PRE;
        s.acc         = '0;
        s.flags       = '0;
        s.error       = 1'b0;
        s.tab_pending = 1'b0;
        return s;
    endfunction

    // A comma opens a fresh item; accumulator, flags and error persist.
    function automatic t_state start_item(t_state si);
        t_state s;
        s             = si;
        s.phase       = PH_ITEM;
        s.name_pos    = '0;
        s.cand        = 4'hf;
        s.inner_space = 1'b0;
        s.saw_equals  = 1'b0;
        s.vphase      = VP_PRE;
        s.tab_pending = 1'b0;
        return s;
    endfunction

    // Returns {found, index}; the lowest matching index wins.
    function automatic logic [2:0] match_name(logic [3:0] cand, logic [3:0] pos);
        logic [2:0] m;
        m = 3'b000;
        for (int i = NAMES_N - 1; i >= 0; i--) begin
            if (cand[i] && pos == KNOWN_LEN[i]) begin
                m = {1'b1, 2'(i)};
            end
        end
        return m;
    endfunction

    function automatic t_state name_char(t_state si, logic [7:0] bi);
        t_state     s;
        logic [7:0] b;
        logic [7:0] k;
        s = si;
        b = bi;
        if (s.inner_space) begin
            s.cand = '0;
        end
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            b = b | CASE_BIT;
        end
        for (int i = 0; i < NAMES_N; i++) begin
            k = KNOWN_NAME[i][{~s.name_pos, 3'b000} +: 8];
            if (s.name_pos >= KNOWN_LEN[i] || k != b) begin
                s.cand[i] = 1'b0;
            end
        end
        if (s.name_pos != 4'hf) begin
            s.name_pos = s.name_pos + 4'd1;
        end
        return s;
    endfunction

    function automatic t_state value_char(t_state si, logic [7:0] b);
        t_state          s;
        logic            blank;
        logic [ACC_W+3:0] wide;
        s     = si;
        blank = (b == CH_SPACE) || (b == CH_TAB);
        wide  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1)
              + (ACC_W + 4)'(b - CH_ZERO);
        if (s.vphase == VP_BAD) begin
            return s;
        end
        if (blank) begin
            if (s.vphase == VP_DIGITS || s.vphase == VP_QCLOSED) begin
                s.vphase = VP_DONE;
            end else if (s.vphase == VP_QOPEN || s.vphase == VP_QDIGITS) begin
                s.vphase = VP_BAD;
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (s.vphase == VP_PRE) begin
                s.vphase = VP_DIGITS;
            end else if (s.vphase == VP_QOPEN) begin
                s.vphase = VP_QDIGITS;
            end else if (s.vphase != VP_DIGITS && s.vphase != VP_QDIGITS) begin
                s.vphase = VP_BAD;
                return s;
            end
            // Value times ten plus the digit must stay within 63 bits.
            if (|wide[ACC_W+3:ACC_W]) begin
                s.vphase = VP_BAD;
            end else begin
                s.acc = wide[ACC_W-1:0];
            end
        end else if (b == CH_QUOTE) begin
            if (s.vphase == VP_PRE) begin
                s.vphase = VP_QOPEN;
            end else if (s.vphase == VP_QDIGITS) begin
                s.vphase = VP_QCLOSED;
            end else begin
                s.vphase = VP_BAD;
            end
        end else begin
            s.vphase = VP_BAD;
        end
        return s;
    endfunction

    function automatic t_state finish_item(t_state si);
        t_state     s;
        logic [2:0] m;
        s = si;
        m = match_name(s.cand, s.name_pos);
        if (m[2]) begin
            case (m[1:0])
                NAME_NO_STORE: begin
                    s.flags[NAME_NO_STORE] = 1'b1;
                end
                NAME_NO_CACHE: begin
                    s.flags[NAME_NO_CACHE] = 1'b1;
                end
                NAME_MUST_REVALIDATE: begin
                    s.flags[NAME_MUST_REVALIDATE] = 1'b1;
                end
                default: begin
                    if (!s.saw_equals || s.flags[NAME_MAX_AGE]) begin
                        s.error = 1'b1;
                    end else if (s.vphase == VP_DIGITS || s.vphase == VP_QCLOSED ||
                                 s.vphase == VP_DONE) begin
                        s.flags[NAME_MAX_AGE] = 1'b1;
                    end else begin
                        s.error = 1'b1;
                    end
                end
            endcase
        end
        return s;
    endfunction

    function automatic t_state take_byte(t_state si, logic [7:0] b);
        t_state     s;
        logic       blank;
        logic [2:0] m;
        s     = si;
        blank = (b == CH_SPACE) || (b == CH_TAB);
        m     = match_name(s.cand, s.name_pos);
        if (s.error) begin
            return s;
        end
        if (!blank && (b < CH_LOW || b >= CH_DEL)) begin
            s.error = 1'b1;
            return s;
        end
        // A tab inside an item may only be followed by blanks or the comma.
        if (!blank && s.tab_pending && b != CH_COMMA) begin
            s.error = 1'b1;
            return s;
        end
        case (s.phase)
            PH_HEADER, PH_ITEM, PH_LEAD: begin
                if (blank) begin
                    s.phase = PH_LEAD;
                end else if (b == CH_COMMA || b == CH_EQUAL) begin
                    s.error = 1'b1;
                end else begin
                    s.phase = PH_NAME;
                    s       = name_char(s, b);
                end
            end
            PH_NAME: begin
                if (blank) begin
                    s.inner_space = 1'b1;
                    if (b == CH_TAB) begin
                        s.tab_pending = 1'b1;
                    end
                end else if (b == CH_COMMA) begin
                    s = start_item(finish_item(s));
                end else if (b == CH_EQUAL) begin
                    if (m[2] && (m[1:0] == NAME_NO_STORE ||
                                 m[1:0] == NAME_MUST_REVALIDATE ||
                                 (m[1:0] == NAME_MAX_AGE && s.flags[NAME_MAX_AGE]))) begin
                        s.error = 1'b1;
                    end else begin
                        s.cand       = m[2] ? (4'b0001 << m[1:0]) : 4'b0000;
                        s.saw_equals = 1'b1;
                        s.phase      = PH_VALUE;
                        s.vphase     = VP_PRE;
                        if (m[2] && m[1:0] == NAME_MAX_AGE) begin
                            s.acc = '0;
                        end
                    end
                end else begin
                    s = name_char(s, b);
                end
            end
            default: begin
                if (b == CH_COMMA) begin
                    s = start_item(finish_item(s));
                end else begin
                    if (b == CH_TAB) begin
                        s.tab_pending = 1'b1;
                    end
                    // Only a max-age value is checked; other values are skipped.
                    if (s.cand == (4'b0001 << NAME_MAX_AGE)) begin
                        s = value_char(s, b);
                    end
                end
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input register and handshake.
    // ------------------------------------------------------------------
    logic     r_in_valid;
    logic     n_in_valid;
    t_in_req  r_in;
    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    logic     n_out_valid;
    t_out_req r_out;
    t_out_req n_out;
    logic     advance;
    logic     in_take;

    // The held request moves on unless it needs a verdict slot that is busy.
    assign advance     = r_in_valid &&
                         (!r_in.last || !r_out_valid || o_verdict.ready);
    assign i_hdr.ready = !r_in_valid || advance;
    assign in_take     = i_hdr.valid && i_hdr.ready;

    always_comb begin
        n_in_valid = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.has_byte   <= i_hdr.has_byte;
            r_in.byte_value <= i_hdr.byte_value;
            r_in.last       <= i_hdr.last;
        end
    end

    // ------------------------------------------------------------------
    // Parser pass: one byte into the state, then the verdict on last.
    // ------------------------------------------------------------------
    always_comb begin
        t_state s;
        logic   ok;
        s = r_state;
        if (r_in.has_byte) begin
            s = take_byte(s, r_in.byte_value);
        end
        if (!s.error) begin
            if (s.phase == PH_LEAD) begin
                // An all-blank item at the end of the header.
                s.error = r_in.last;
            end else if (r_in.last && (s.phase == PH_NAME || s.phase == PH_VALUE)) begin
                s = finish_item(s);
            end
        end
        ok                    = !s.error;
        n_out.header_valid    = ok;
        n_out.store_ban       = ok && s.flags[NAME_NO_STORE];
        n_out.cache_ban       = ok && s.flags[NAME_NO_CACHE];
        n_out.reval_req       = ok && s.flags[NAME_MUST_REVALIDATE];
        n_out.age_present     = ok && s.flags[NAME_MAX_AGE];
        n_out.age_seconds     = (ok && s.flags[NAME_MAX_AGE]) ? s.acc : '0;
        if (!advance) begin
            n_state = r_state;
        end else if (r_in.last) begin
            n_state = reset_state();
        end else begin
            n_state = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= reset_state();
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Verdict register.
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && o_verdict.ready) begin
            n_out_valid = 1'b0;
        end
        if (advance && r_in.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_verdict.valid        = r_out_valid;
    assign o_verdict.header_valid = r_out.header_valid;
    assign o_verdict.store_ban    = r_out.store_ban;
    assign o_verdict.cache_ban    = r_out.cache_ban;
    assign o_verdict.reval_req    = r_out.reval_req;
    assign o_verdict.age_present  = r_out.age_present;
    assign o_verdict.age_seconds  = r_out.age_seconds;

endmodule : cache_control_directive_parser_top
`default_nettype wire

@@ tb/cache_control_directive_parser_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache-Control directive parser testbench
// Feeds header bytes through the request channel and checks every verdict
// against a cycle-free predictor of the parser kept inside the bench.
// ----------------------------------------------------------------------------
module cache_control_directive_parser_top_tb;

    import cc_dir_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int IDLE_PCT         = 12;
    localparam int BROKEN_PCT       = 20;
    localparam int MISMATCH_SHOWN   = 10;
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 8;
    localparam int TIMEOUT_NS       = 4_000_000;

    localparam logic [63:0] MAX_AGE_LIMIT = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] DEC_RADIX     = 64'd10;

    typedef logic [7:0] t_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cc_dir_in_if  hdr_if ();
    cc_dir_out_if verdict_if ();

    cache_control_directive_parser_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hdr     (hdr_if),
        .o_verdict (verdict_if)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Text used to build headers. The directive names are kept here in plain
    // lower case; indexes follow the NAME_* constants of the package.
    // ------------------------------------------------------------------------
    string known_names [NAMES_N] = '{"no-store", "no-cache", "must-revalidate", "max-age"};
    string other_tokens [8] = '{"private", "public", "s-maxage=60", "proxy-revalidate",
                                "immutable", "stale-while-revalidate=30", "no-transform",
                                "ext=\"a b\""};
    string near_names [6] = '{"no-stor", "max-ages=5", "no-store-x", "must-revalidat",
                              "maxage=1", "no-cach"};
    // Values right at and around the 63-bit ceiling.
    string age_edges [5] = '{"9223372036854775807", "9223372036854775808",
                             "922337203685477580", "9223372036854775810",
                             "18446744073709551616"};

    // ------------------------------------------------------------------------
    // Parser predictor. It mirrors the parser state one request at a time and
    // queues a verdict for every request that carries last.
    // ------------------------------------------------------------------------
    t_phase           st_phase;
    logic [3:0]       st_pos;
    logic [3:0]       st_cand;
    logic             st_inner;
    logic             st_eq;
    t_vphase          st_vph;
    logic [ACC_W-1:0] st_acc;
    logic [3:0]       st_flags;
    logic             st_err;
    logic             st_tab;

    t_out_req pending_verdicts [$];

    int  mismatches    = 0;
    int  verdicts_seen = 0;
    int  reqs_sent     = 0;
    bit  src_calm      = 1'b0;
    bit  snk_calm      = 1'b0;
    int  snk_hold_req  = 0;

    function automatic void hdr_item_start();
        st_phase = PH_ITEM;
        st_pos   = '0;
        st_cand  = 4'hf;
        st_inner = 1'b0;
        st_eq    = 1'b0;
        st_vph   = VP_PRE;
        st_tab   = 1'b0;
    endfunction

    function automatic void hdr_reset_state();
        hdr_item_start();
        st_phase = PH_HEADER;
        st_acc   = '0;
        st_flags = '0;
        st_err   = 1'b0;
    endfunction

    // Index of the known name that the item spells exactly, or -1.
    function automatic int hdr_matched_name();
        for (int i = 0; i < NAMES_N; i++) begin
            if (st_cand[i] && int'(st_pos) == known_names[i].len()) return i;
        end
        return -1;
    endfunction

    function automatic void hdr_name_char(t_byte b);
        t_byte lc;
        lc = b;
        if (st_inner) st_cand = '0;
        if (lc >= CH_UP_A && lc <= CH_UP_Z) lc = lc | CASE_BIT;
        for (int i = 0; i < NAMES_N; i++) begin
            if (int'(st_pos) >= known_names[i].len() || known_names[i][st_pos] != lc)
                st_cand[i] = 1'b0;
        end
        if (st_pos != 4'd15) st_pos = st_pos + 4'd1;
    endfunction

    function automatic void hdr_value_char(t_byte b);
        logic        blank;
        logic [63:0] digit;
        blank = (b == CH_SPACE || b == CH_TAB);
        digit = {56'b0, t_byte'(b - CH_ZERO)};
        if (st_vph == VP_BAD) return;
        if (blank) begin
            if (st_vph == VP_DIGITS || st_vph == VP_QCLOSED) st_vph = VP_DONE;
            else if (st_vph == VP_QOPEN || st_vph == VP_QDIGITS) st_vph = VP_BAD;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (st_vph == VP_PRE) st_vph = VP_DIGITS;
            else if (st_vph == VP_QOPEN) st_vph = VP_QDIGITS;
            else if (st_vph != VP_DIGITS && st_vph != VP_QDIGITS) begin
                st_vph = VP_BAD;
                return;
            end
            if ({1'b0, st_acc} > (MAX_AGE_LIMIT - digit) / DEC_RADIX) st_vph = VP_BAD;
            else st_acc = ACC_W'(st_acc * DEC_RADIX + digit);
        end else if (b == CH_QUOTE) begin
            if (st_vph == VP_PRE) st_vph = VP_QOPEN;
            else if (st_vph == VP_QDIGITS) st_vph = VP_QCLOSED;
            else st_vph = VP_BAD;
        end else begin
            st_vph = VP_BAD;
        end
    endfunction

    function automatic void hdr_finish_item();
        int m;
        m = hdr_matched_name();
        if (m == NAME_NO_STORE) st_flags[NAME_NO_STORE] = 1'b1;
        else if (m == NAME_NO_CACHE) st_flags[NAME_NO_CACHE] = 1'b1;
        else if (m == NAME_MUST_REVALIDATE) st_flags[NAME_MUST_REVALIDATE] = 1'b1;
        else if (m == NAME_MAX_AGE) begin
            if (!st_eq || st_flags[NAME_MAX_AGE]) st_err = 1'b1;
            else if (st_vph == VP_DIGITS || st_vph == VP_QCLOSED || st_vph == VP_DONE)
                st_flags[NAME_MAX_AGE] = 1'b1;
            else st_err = 1'b1;
        end
    endfunction

    function automatic void hdr_take_byte(t_byte b);
        logic blank;
        int   m;
        blank = (b == CH_SPACE || b == CH_TAB);
        if (st_err) return;
        if (!blank && (b < CH_LOW || b >= CH_DEL)) begin
            st_err = 1'b1;
            return;
        end
        // A tab may only trail an item: anything but a comma after it is an error.
        if (!blank && st_tab && b != CH_COMMA) begin
            st_err = 1'b1;
            return;
        end
        case (st_phase)
            PH_HEADER, PH_ITEM, PH_LEAD: begin
                if (blank) st_phase = PH_LEAD;
                else if (b == CH_COMMA || b == CH_EQUAL) st_err = 1'b1;
                else begin
                    st_phase = PH_NAME;
                    hdr_name_char(b);
                end
            end
            PH_NAME: begin
                if (blank) begin
                    st_inner = 1'b1;
                    if (b == CH_TAB) st_tab = 1'b1;
                end else if (b == CH_COMMA) begin
                    hdr_finish_item();
                    hdr_item_start();
                end else if (b == CH_EQUAL) begin
                    m = hdr_matched_name();
                    if (m == NAME_NO_STORE || m == NAME_MUST_REVALIDATE ||
                        (m == NAME_MAX_AGE && st_flags[NAME_MAX_AGE])) begin
                        st_err = 1'b1;
                        return;
                    end
                    st_cand  = (m >= 0) ? (4'b0001 << m) : 4'b0000;
                    st_eq    = 1'b1;
                    st_phase = PH_VALUE;
                    st_vph   = VP_PRE;
                    if (m == NAME_MAX_AGE) st_acc = '0;
                end else begin
                    hdr_name_char(b);
                end
            end
            default: begin
                if (b == CH_COMMA) begin
                    hdr_finish_item();
                    hdr_item_start();
                    return;
                end
                if (b == CH_TAB) st_tab = 1'b1;
                // Only a max-age value is parsed; other values are skipped.
                if (st_cand == (4'b0001 << NAME_MAX_AGE)) hdr_value_char(b);
            end
        endcase
    endfunction

    function automatic void hdr_model_request(logic hb, t_byte b, logic lst);
        t_out_req v;
        if (hb) hdr_take_byte(b);
        if (!lst) return;
        if (!st_err) begin
            if (st_phase == PH_LEAD) st_err = 1'b1;
            else if (st_phase == PH_NAME || st_phase == PH_VALUE) hdr_finish_item();
        end
        v = '0;
        if (!st_err) begin
            v.header_valid = 1'b1;
            v.store_ban    = st_flags[NAME_NO_STORE];
            v.cache_ban    = st_flags[NAME_NO_CACHE];
            v.reval_req    = st_flags[NAME_MUST_REVALIDATE];
            v.age_present  = st_flags[NAME_MAX_AGE];
            v.age_seconds  = st_flags[NAME_MAX_AGE] ? st_acc : '0;
        end
        pending_verdicts.push_back(v);
        hdr_reset_state();
    endfunction

    // ------------------------------------------------------------------------
    // Verdict checker. Every verdict taken on the output channel is compared
    // field by field with the oldest predicted verdict.
    // ------------------------------------------------------------------------
    task automatic check_field(string fld, logic [62:0] want, logic [62:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
                $display("[%0t] verdict %0d: %s expected 0x%0h, got 0x%0h",
                         $time, verdicts_seen, fld, want, got);
        end
    endtask

    always @(posedge i_clk) begin : verdict_check
        t_out_req want;
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN)
                    $display("[%0t] verdict %0d arrived with none predicted",
                             $time, verdicts_seen);
            end else begin
                want = pending_verdicts.pop_front();
                check_field("header_valid", ACC_W'(want.header_valid),
                            ACC_W'(verdict_if.header_valid));
                check_field("store_ban", ACC_W'(want.store_ban),
                            ACC_W'(verdict_if.store_ban));
                check_field("cache_ban", ACC_W'(want.cache_ban),
                            ACC_W'(verdict_if.cache_ban));
                check_field("reval_req", ACC_W'(want.reval_req),
                            ACC_W'(verdict_if.reval_req));
                check_field("age_present", ACC_W'(want.age_present),
                            ACC_W'(verdict_if.age_present));
                check_field("age_seconds", want.age_seconds,
                            verdict_if.age_seconds);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Verdict ready. Normally ready drops in about one cycle of eight; a test
    // can ask for a long hold-off, which this process counts out by itself.
    // ------------------------------------------------------------------------
    initial begin : verdict_ready_drv
        int hold_left;
        forever begin
            if (snk_hold_req > 0) begin
                hold_left    = snk_hold_req;
                snk_hold_req = 0;
                verdict_if.ready <= 1'b0;
                repeat (hold_left) @(posedge i_clk);
            end else begin
                verdict_if.ready <= snk_calm || ($urandom_range(0, 99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. One request is offered, held until the parser takes it,
    // and then handed to the predictor. Valid is lowered only to idle, so a
    // back-to-back request keeps it high with a single assignment per edge.
    // ------------------------------------------------------------------------
    task automatic send_req(input logic hb, input t_byte b, input logic lst);
        while (!src_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            hdr_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        hdr_if.valid      <= 1'b1;
        hdr_if.has_byte   <= hb;
        hdr_if.byte_value <= b;
        hdr_if.last       <= lst;
        @(posedge i_clk);
        while (!hdr_if.ready) @(posedge i_clk);
        hdr_model_request(hb, b, lst);
        reqs_sent++;
    endtask

    // Sends one header. Now and then a request without byte or last is slipped
    // in; with end_marker the header closes on a request that has no byte.
    task automatic send_header(input t_byte q[$], input bit end_marker);
        if (q.size() == 0) begin
            send_req(1'b0, t_byte'($urandom), 1'b1);
            return;
        end
        foreach (q[i]) begin
            if ($urandom_range(0, 99) < 5) send_req(1'b0, t_byte'($urandom), 1'b0);
            send_req(1'b1, q[i], !end_marker && (i == q.size() - 1));
        end
        if (end_marker) send_req(1'b0, t_byte'($urandom), 1'b1);
    endtask

    // Waits until every predicted verdict has been taken, with valid low.
    task automatic wait_verdicts_drained();
        hdr_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Header builders.
    // ------------------------------------------------------------------------
    function automatic void push_text(ref t_byte q[$], input string s, input bit mix_case);
        t_byte c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 2) == 0)
                c = c ^ CASE_BIT;
            q.push_back(c);
        end
    endfunction

    function automatic void push_blanks(ref t_byte q[$], input bit allow_tab);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                q.push_back((allow_tab && $urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
        end
    endfunction

    // Mostly short values, some long ones, some with leading zeros, and some
    // right at the 63-bit overflow edge.
    function automatic void push_digits(ref t_byte q[$]);
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel == 8) begin
            push_text(q, age_edges[$urandom_range(0, 4)], 1'b0);
        end else begin
            if (sel == 9) repeat ($urandom_range(1, 20)) q.push_back(CH_ZERO);
            n = (sel == 7) ? $urandom_range(5, 19) : $urandom_range(1, 4);
            repeat (n) q.push_back(t_byte'(CH_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void push_max_age(ref t_byte q[$], input bit quoted);
        push_text(q, known_names[NAME_MAX_AGE], 1'b1);
        push_blanks(q, 1'b0);
        q.push_back(CH_EQUAL);
        push_blanks(q, 1'b0);
        if (quoted) q.push_back(CH_QUOTE);
        push_digits(q);
        if (quoted) q.push_back(CH_QUOTE);
    endfunction

    function automatic void push_directive(ref t_byte q[$]);
        push_blanks(q, 1'b1);
        case ($urandom_range(0, 11))
            0:       push_text(q, known_names[NAME_NO_STORE], 1'b1);
            1:       push_text(q, known_names[NAME_NO_CACHE], 1'b1);
            2:       push_text(q, known_names[NAME_MUST_REVALIDATE], 1'b1);
            3, 4, 5: push_max_age(q, 1'b0);
            6:       push_max_age(q, 1'b1);
            7: begin
                push_text(q, known_names[NAME_NO_CACHE], 1'b1);
                push_text(q, "=\"set-cookie\"", 1'b0);
            end
            8:       push_text(q, other_tokens[$urandom_range(0, 7)], 1'b1);
            9:       push_text(q, near_names[$urandom_range(0, 5)], 1'b1);
            // max-age without a value is an error.
            10:      push_text(q, known_names[NAME_MAX_AGE], 1'b1);
            default: begin
                push_max_age(q, 1'($urandom_range(0, 1)));
                q.push_back(CH_SPACE);
            end
        endcase
        push_blanks(q, 1'b1);
    endfunction

    // One random damage: a random or control byte, a stray comma, equals sign,
    // quote or tab, or a lost byte.
    function automatic void mangle_header(ref t_byte q[$]);
        int pos;
        pos = (q.size() != 0) ? $urandom_range(0, q.size() - 1) : 0;
        case ($urandom_range(0, 5))
            0: begin
                if (q.size() != 0) q[pos] = t_byte'($urandom_range(0, 255));
                else q.push_back(t_byte'($urandom_range(0, 255)));
            end
            1: q.insert(pos, $urandom_range(0, 1) ? t_byte'($urandom_range(0, 31))
                                                   : t_byte'($urandom_range(127, 255)));
            2: q.insert(pos, CH_COMMA);
            3: if (q.size() != 0) q.delete(pos);
            4: q.insert(pos, $urandom_range(0, 1) ? CH_EQUAL : CH_QUOTE);
            default: q.insert(pos, CH_TAB);
        endcase
    endfunction

    function automatic void build_header(ref t_byte q[$], input bit broken);
        int n_dir;
        q.delete();
        n_dir = $urandom_range(1, 4);
        for (int k = 0; k < n_dir; k++) begin
            if (k != 0) q.push_back(CH_COMMA);
            push_directive(q);
        end
        // A single trailing comma is legal.
        if ($urandom_range(0, 9) == 0) q.push_back(CH_COMMA);
        if (broken) repeat ($urandom_range(1, 2)) mangle_header(q);
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Short hand-picked headers: the empty header, an ignored request, a legal
    // trailing comma, an empty item, bytes at both ends of the byte range and
    // just outside the printable range, an all-blank item, an empty name, a
    // tab inside an item and an empty item between two names.
    task automatic test_edge_bytes();
        send_req(1'b0, 8'ha5, 1'b1);
        send_req(1'b0, 8'h5a, 1'b0);
        send_req(1'b1, "a", 1'b1);
        send_req(1'b1, CH_COMMA, 1'b1);
        send_req(1'b1, "a", 1'b0);
        send_req(1'b1, CH_COMMA, 1'b1);
        send_req(1'b1, 8'hff, 1'b1);
        send_req(1'b1, 8'h00, 1'b1);
        send_req(1'b1, CH_DEL, 1'b1);
        send_req(1'b1, 8'h1f, 1'b1);
        send_req(1'b1, 8'h7e, 1'b1);
        send_req(1'b1, CH_SPACE, 1'b1);
        send_req(1'b1, CH_EQUAL, 1'b1);
        send_req(1'b1, "x", 1'b0);
        send_req(1'b1, CH_TAB, 1'b0);
        send_req(1'b1, "y", 1'b1);
        send_req(1'b1, "a", 1'b0);
        send_req(1'b1, CH_COMMA, 1'b0);
        send_req(1'b1, CH_COMMA, 1'b0);
        send_req(1'b1, "b", 1'b1);
    endtask

    // Random headers, most of them well formed, some damaged.
    task automatic test_random_headers(input int n_reqs);
        t_byte q[$];
        int    stop_at;
        stop_at = reqs_sent + n_reqs;
        while (reqs_sent < stop_at) begin
            build_header(q, $urandom_range(0, 99) < BROKEN_PCT);
            send_header(q, $urandom_range(0, 7) == 0);
        end
    endtask

    // A stretch where neither side ever idles.
    task automatic test_back_to_back(input int n_reqs);
        src_calm = 1'b1;
        snk_calm = 1'b1;
        test_random_headers(n_reqs);
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    // The verdict side holds off for a long while as one-byte headers keep
    // coming, so the verdict register and then the input register fill up and
    // the request channel stalls.
    task automatic test_verdict_backpressure();
        src_calm     = 1'b1;
        snk_hold_req = SINK_HOLD_CYCLES;
        repeat (12) send_req(1'b1, t_byte'($urandom_range(8'h61, 8'h7a)), 1'b1);
        test_random_headers(40);
        src_calm = 1'b0;
    endtask

    // The sender stops after each header until its verdict has been taken.
    task automatic test_drain_pause();
        t_byte q[$];
        repeat (6) begin
            build_header(q, 1'b0);
            send_header(q, 1'b0);
            wait_verdicts_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        hdr_reset_state();
        i_rst_n           <= 1'b0;
        hdr_if.valid      <= 1'b0;
        hdr_if.has_byte   <= 1'b0;
        hdr_if.byte_value <= '0;
        hdr_if.last       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_bytes();
        test_random_headers(800);
        test_back_to_back(150);
        test_verdict_backpressure();
        test_drain_pause();
        test_random_headers(400);

        // Let the last verdicts out, then watch a little longer for strays.
        hdr_if.valid <= 1'b0;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_verdicts.size() != 0)
            $display("%0d predicted verdicts never arrived", pending_verdicts.size());
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop in case the request or verdict channel hangs.
    initial begin
        #TIMEOUT_NS;
        $display("run timed out");
        $display("FAILURE");
        $finish;
    end

endmodule : cache_control_directive_parser_top_tb

@@ cache_control_directive_parser_top.f @@
hdl/cc_dir_pkg.sv
hdl/cc_dir_if.sv
hdl/cache_control_directive_parser_top.sv
tb/cache_control_directive_parser_top_tb.sv
